// File: hdl/aes128_ctr_stream_cipher_assert.svh
// Assertion macros shared by the cipher RTL, clocked on clk, off while rst_n is low
`ifndef AES128_CTR_STREAM_CIPHER_ASSERT_SVH
`define AES128_CTR_STREAM_CIPHER_ASSERT_SVH
// same-cycle implication
`define ACS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acs assertion failed");
// next-cycle implication
`define ACS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acs assertion failed");
`endif

// File: hdl/acs_pkg.sv
// Package: AES-128 tables, round functions and shared types
`default_nettype none
package acs_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned REG_W   = 64;
    localparam int unsigned IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_KEY_UPPER = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOWER = 3'd1;
    localparam logic [IDX_W-1:0] REG_IV_UPPER  = 3'd2;
    localparam logic [IDX_W-1:0] REG_IV_LOWER  = 3'd3;

    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef struct packed {
        logic                 ready;
        logic [BLOCK_W-1:0]   block;
    } ks_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the previous one (four words, word 0 in the top bits)
    function automatic logic [127:0] key_step(input logic [127:0] w, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] n0;
        logic [31:0] n1;
        logic [31:0] n2;
        logic [31:0] n3;
        t  = {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]} ^ {rc, 24'h000000};
        n0 = w[127:96] ^ t;
        n1 = w[95:64] ^ n0;
        n2 = w[63:32] ^ n1;
        n3 = w[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // one round (MixColumns skipped when last is set); byte i of the state sits at bits 127-8i down
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                               input logic last);
        logic [7:0]   a [16];
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            a[i] = SBOX[s[127-8*i -: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int w = 0; w < 4; w++)
            begin
                t[c*4+w] = a[((c + w) & 3)*4 + w];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[c*4]   = xtime(t[c*4]) ^ xtime(t[c*4+1]) ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
            m[c*4+1] = t[c*4] ^ xtime(t[c*4+1]) ^ xtime(t[c*4+2]) ^ t[c*4+2] ^ t[c*4+3];
            m[c*4+2] = t[c*4] ^ t[c*4+1] ^ xtime(t[c*4+2]) ^ xtime(t[c*4+3]) ^ t[c*4+3];
            m[c*4+3] = xtime(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ xtime(t[c*4+3]);
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127-8*i -: 8] = (last ? t[i] : m[i]) ^ k[127-8*i -: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/acs_byte_fifo.sv
// Input byte queue between the stream slave side and the keystream mixer
`default_nettype none
module acs_byte_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire logic [7:0] wr_data,
    output logic            full,
    input  wire logic       rd_en,
    output logic [7:0]      rd_data,
    output logic            empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/acs_ks_core.sv
// Iterative AES-128 counter encipher, one round per cycle, key schedule on the fly
`default_nettype none
module acs_ks_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         restart,
    input  wire logic [127:0] key,
    input  wire logic [127:0] iv,
    input  wire logic         take,
    output acs_pkg::ks_status_t status
);
    logic         busy_reg;
    logic         done_reg;
    logic [3:0]   round_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_reg;
    logic [127:0] ctr_reg;
    logic [127:0] rk_next;

    assign rk_next      = acs_pkg::key_step(rk_reg, acs_pkg::rcon(round_reg));
    assign status.ready = done_reg;
    assign status.block = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
            ctr_reg   <= '0;
            st_reg    <= '0;
            rk_reg    <= '0;
        end
        else if (restart)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ctr_reg  <= iv;
        end
        else if (busy_reg)
        begin
            rk_reg    <= rk_next;
            st_reg    <= acs_pkg::aes_round(st_reg, rk_next, round_reg == acs_pkg::LAST_ROUND);
            round_reg <= round_reg + 1'b1;
            if (round_reg == acs_pkg::LAST_ROUND)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else if (!done_reg)
        begin
            // start the next block straight away so it is ready ahead of use
            st_reg    <= ctr_reg ^ key;
            rk_reg    <= key;
            ctr_reg   <= ctr_reg + 128'd1;
            round_reg <= 4'd1;
            busy_reg  <= 1'b1;
        end
        else if (take)
        begin
            done_reg <= 1'b0;
        end
    end

`include "aes128_ctr_stream_cipher_assert.svh"
    `ACS_ASSERT_NOW(a_busy_done_excl, 1'b1, !(busy_reg && done_reg))
    `ACS_ASSERT_NOW(a_round_range, busy_reg, round_reg >= 4'd1 && round_reg <= acs_pkg::LAST_ROUND)
    `ACS_ASSERT_NEXT(a_last_round_done, busy_reg && !restart && round_reg == acs_pkg::LAST_ROUND,
                     done_reg)
endmodule
`default_nettype wire

// File: hdl/aes128_ctr_stream_cipher.sv
// Top level: AES-128 CTR byte stream cipher with config registers and output register
// A byte is written into the queue, then XORed with the keystream into the output register.
// Bytes pass back to back while the buffer holds keystream and the output is not stalled.
// No byte passes while a block is swapped in; the core runs ahead, hidden in steady flow.
// After reset or a write to a mapped config register the first byte waits for a fresh block.
// Reset (rst_n low, async): key and IV clear to zero, queue and keystream buffer emptied.
`default_nettype none
module aes128_ctr_stream_cipher #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [acs_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [acs_pkg::REG_W-1:0]   cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [7:0]                       m_axis_tdata    // [7:0] out_byte
);
    // configuration registers
    logic [63:0] key_upper_reg, key_upper_next;
    logic [63:0] key_lower_reg, key_lower_next;
    logic [63:0] iv_upper_reg,  iv_upper_next;
    logic [63:0] iv_lower_reg,  iv_lower_next;
    logic        restart;

    // keystream buffer: ks_cnt_reg counts bytes used, 16 means used up
    logic [127:0] ks_reg;
    logic [4:0]   ks_cnt_reg;
    logic [127:0] ks_shift;
    logic         ks_load;

    logic         fifo_full;
    logic         fifo_empty;
    logic [7:0]   fifo_head;
    logic         consume;

    logic         out_valid_reg;
    logic [7:0]   out_data_reg;

    acs_pkg::ks_status_t core_status;

    always_comb
    begin
        key_upper_next = key_upper_reg;
        key_lower_next = key_lower_reg;
        iv_upper_next  = iv_upper_reg;
        iv_lower_next  = iv_lower_reg;
        restart        = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                acs_pkg::REG_KEY_UPPER: begin key_upper_next = cfg_data; restart = 1'b1; end
                acs_pkg::REG_KEY_LOWER: begin key_lower_next = cfg_data; restart = 1'b1; end
                acs_pkg::REG_IV_UPPER:  begin iv_upper_next  = cfg_data; restart = 1'b1; end
                acs_pkg::REG_IV_LOWER:  begin iv_lower_next  = cfg_data; restart = 1'b1; end
                default:                restart = 1'b0;  // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            iv_upper_reg  <= '0;
            iv_lower_reg  <= '0;
        end
        else
        begin
            key_upper_reg <= key_upper_next;
            key_lower_reg <= key_lower_next;
            iv_upper_reg  <= iv_upper_next;
            iv_lower_reg  <= iv_lower_next;
        end
    end

    // front: byte queue
    assign s_axis_tready = !fifo_full;

    acs_byte_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s_axis_tvalid && s_axis_tready),
        .wr_data (s_axis_tdata),
        .full    (fifo_full),
        .rd_en   (consume),
        .rd_data (fifo_head),
        .empty   (fifo_empty)
    );

    // back: keystream generator
    acs_ks_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .key     ({key_upper_reg, key_lower_reg}),
        .iv      ({iv_upper_next, iv_lower_next}),
        .take    (ks_load),
        .status  (core_status)
    );

    // buffer swaps in a finished block once the current one is used up
    assign ks_load  = (ks_cnt_reg == 5'd16) && core_status.ready && !restart;
    assign consume  = !fifo_empty && !ks_cnt_reg[4] && (!out_valid_reg || m_axis_tready);
    assign ks_shift = ks_reg << {ks_cnt_reg[3:0], 3'b000};

    always_ff @(posedge clk)
    begin
        if (ks_load)
        begin
            ks_reg <= core_status.block;
        end
        if (consume)
        begin
            out_data_reg <= fifo_head ^ ks_shift[127:120];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_cnt_reg    <= 5'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                ks_cnt_reg <= 5'd16;
            end
            else if (ks_load)
            begin
                ks_cnt_reg <= '0;
            end
            else if (consume)
            begin
                ks_cnt_reg <= ks_cnt_reg + 1'b1;
            end

            if (consume)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`include "aes128_ctr_stream_cipher_assert.svh"
    `ACS_ASSERT_NOW(a_cnt_range, 1'b1, ks_cnt_reg <= 5'd16)
    `ACS_ASSERT_NOW(a_consume_has_ks, consume, ks_cnt_reg < 5'd16)
    `ACS_ASSERT_NEXT(a_load_resets_cnt, ks_load, ks_cnt_reg == 5'd0)
endmodule
`default_nettype wire

// File: test/aes128_ctr_stream_cipher_test.sv
// Self-checking bench for the AES-128 CTR byte stream cipher: directed table, then random phases
`timescale 1ns / 1ps
`default_nettype none
module aes128_ctr_stream_cipher_test;

    // one row of the directed plan: a register write or a data byte
    typedef struct packed {
        logic                      is_cfg;
        logic [acs_pkg::IDX_W-1:0] idx;
        logic [acs_pkg::REG_W-1:0] val;
        logic [7:0]                din;
        logic                      known;   // golden value typed in below
        logic [7:0]                golden;
    } plan_row_t;

    localparam int          PLAN_ROWS   = 30;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] ONES        = 64'hffff_ffff_ffff_ffff;
    localparam logic [acs_pkg::IDX_W-1:0] REG_BAD_LOW  = 3'd4;
    localparam logic [acs_pkg::IDX_W-1:0] REG_BAD_HIGH = 3'd7;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [acs_pkg::IDX_W-1:0]    cfg_index;
    logic [acs_pkg::REG_W-1:0]    cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata;    // [7:0] data_byte
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [7:0]                   m_axis_tdata;    // [7:0] out_byte

    aes128_ctr_stream_cipher i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ---------------------------------------------------------------
    // Cipher predictor: own copy of the registers and keystream state
    // ---------------------------------------------------------------
    logic [63:0]  shadow_key_hi;
    logic [63:0]  shadow_key_lo;
    logic [63:0]  shadow_iv_hi;
    logic [63:0]  shadow_iv_lo;
    logic [31:0]  sched [44];
    logic [127:0] ctr;
    logic [7:0]   pad [16];
    int           pad_pos;

    logic [7:0]   expected_bytes [$];
    int           mismatches;
    bit           no_gaps;        // phase with back-to-back transfers on both sides

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // key schedule plus counter reload; keystream marked as used up
    function automatic void rekey();
        logic [31:0] t;
        logic [7:0]  rc;
        sched[0] = shadow_key_hi[63:32];
        sched[1] = shadow_key_hi[31:0];
        sched[2] = shadow_key_lo[63:32];
        sched[3] = shadow_key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = sched[i-1];
            if (i % 4 == 0)
            begin
                t = {acs_pkg::SBOX[t[23:16]], acs_pkg::SBOX[t[15:8]],
                     acs_pkg::SBOX[t[7:0]], acs_pkg::SBOX[t[31:24]]}
                    ^ {rc, 24'h0};
                rc = gf_double(rc);
            end
            sched[i] = sched[i-4] ^ t;
        end
        ctr     = {shadow_iv_hi, shadow_iv_lo};
        pad_pos = 16;
    endfunction

    function automatic void add_key(inout logic [7:0] st [16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                st[c*4+r] ^= sched[rnd*4+c][31-8*r -: 8];
    endfunction

    // forward cipher of the counter into the pad, then counter + 1 (wraps)
    function automatic void refill_pad();
        logic [7:0] st [16];
        logic [7:0] sh [16];
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
            st[i] = ctr[127-8*i -: 8];
        add_key(st, 0);
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int i = 0; i < 16; i++)
                st[i] = acs_pkg::SBOX[st[i]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[c*4+r] = st[((c + r) % 4)*4 + r];
            st = sh;
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
                    st[c*4]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    st[c*4+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    st[c*4+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    st[c*4+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end
            end
            add_key(st, rnd);
        end
        pad     = st;
        ctr     = ctr + 128'd1;
        pad_pos = 0;
    endfunction

    function automatic logic [7:0] cipher_byte(input logic [7:0] b);
        logic [7:0] r;
        if (pad_pos >= 16)
            refill_pad();
        r = b ^ pad[pad_pos];
        pad_pos++;
        return r;
    endfunction

    function automatic void shadow_write(input logic [acs_pkg::IDX_W-1:0] idx,
                                         input logic [63:0] v);
        case (idx)
            acs_pkg::REG_KEY_UPPER: shadow_key_hi = v;
            acs_pkg::REG_KEY_LOWER: shadow_key_lo = v;
            acs_pkg::REG_IV_UPPER:  shadow_iv_hi  = v;
            acs_pkg::REG_IV_LOWER:  shadow_iv_lo  = v;
            default:                return;  // unmapped index: no restart
        endcase
        rekey();
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, cycle limit
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int n = 0; n < CYCLE_LIMIT; n++)
            @(posedge clk);
        $display("%0t: timeout with %0d bytes outstanding", $time, expected_bytes.size());
        $display("aes128_ctr_stream_cipher regression: fail");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // Output side: random back-pressure, check every transfer
    // ---------------------------------------------------------------
    initial
    begin
        int stall;
        logic [7:0] want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected out_byte, expected none, actual %02h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side tasks; all called from the negedge
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic known, input logic [7:0] golden);
        int gap;
        logic [7:0] pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= b;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = cipher_byte(b);
        expected_bytes.push_back(known ? golden : pred);
        @(negedge clk);
    endtask

    // registers move only once every byte is back and the pipeline has drained
    task automatic write_reg(input logic [acs_pkg::IDX_W-1:0] idx, input logic [63:0] v);
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_write(idx, v);
    endtask

    function automatic logic [63:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0:       return 64'h0;
            1:       return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Directed plan. Golden bytes after reset: AES-128 of the zero block under
    // the zero key starts 66 e9 4b d4.
    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h00, 1'b1, 8'h66},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hff, 1'b1, 8'h16},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h00, 1'b1, 8'h4b},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h80, 1'b0, 8'h00},
        // all-ones counter: the second block must come from a wrapped zero counter
        '{1'b1, acs_pkg::REG_KEY_UPPER, 64'h2b7e151628aed2a6, 8'h00, 1'b0, 8'h00},
        '{1'b1, acs_pkg::REG_KEY_LOWER, 64'habf7158809cf4f3c, 8'h00, 1'b0, 8'h00},
        '{1'b1, acs_pkg::REG_IV_UPPER,  ONES, 8'h00, 1'b0, 8'h00},
        '{1'b1, acs_pkg::REG_IV_LOWER,  ONES, 8'h00, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h01, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h02, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h04, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h08, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h10, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h20, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h40, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h80, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hfe, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hfd, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hfb, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hf7, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hef, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hdf, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'hbf, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h7f, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h55, 1'b0, 8'h00},   // first byte after the wrap
        // unmapped index: keystream carries on mid-block
        '{1'b1, REG_BAD_LOW,            ONES, 8'h00, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'haa, 1'b0, 8'h00},
        '{1'b1, REG_BAD_HIGH,           64'h0, 8'h00, 1'b0, 8'h00},
        '{1'b0, acs_pkg::REG_KEY_UPPER, 64'h0, 8'h3c, 1'b0, 8'h00},
        // all-ones key restarts from the IV
        '{1'b1, acs_pkg::REG_KEY_UPPER, ONES, 8'h00, 1'b0, 8'h00}
    };

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int n_bytes;
        logic [acs_pkg::IDX_W-1:0] idx;
        mismatches    = 0;
        no_gaps       = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        shadow_key_hi = '0;
        shadow_key_lo = '0;
        shadow_iv_hi  = '0;
        shadow_iv_lo  = '0;
        rekey();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].val);
            else
                send_byte(plan[i].din, plan[i].known, plan[i].golden);
        end
        send_byte(8'h00, 1'b0, 8'h00);

        // random phases: new settings, then a burst of random bytes
        for (int ph = 0; ph < 14; ph++)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < 4; r++)
                if ($urandom_range(0, 1) == 1 || r == ph % 4)
                    write_reg(acs_pkg::IDX_W'(r), pick_reg_value());
            if ($urandom_range(0, 5) == 0)
            begin
                idx = acs_pkg::IDX_W'($urandom_range(4, 7));
                write_reg(idx, pick_reg_value());
            end
            n_bytes = $urandom_range(20, 90);
            for (int k = 0; k < n_bytes; k++)
                send_byte(8'($urandom_range(0, 255)), 1'b0, 8'h00);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (mismatches == 0)
            $display("aes128_ctr_stream_cipher regression: pass");
        else
            $display("aes128_ctr_stream_cipher regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/acs_pkg.sv
hdl/acs_byte_fifo.sv
hdl/acs_ks_core.sv
hdl/aes128_ctr_stream_cipher.sv
test/aes128_ctr_stream_cipher_test.sv
